>>> hw/rtl/tx_wire_parser_assert.svh
// Assertion macros used by the transaction parser RTL.
`ifndef TX_WIRE_PARSER_ASSERT_SVH
`define TX_WIRE_PARSER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define TXP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define TXP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/txp_pkg.sv
// Types, codes and helpers of the transaction parser.
`timescale 1ns / 1ps
package txp_pkg;

  localparam int unsigned INDEX_BITS_DEFAULT = 32;
  localparam int unsigned ID_BYTES           = 32;
  localparam int unsigned ID_WORDS           = 4;
  localparam int unsigned MAX_RESULTS        = 5;
  localparam int unsigned M_TDATA_W          = 104;
  localparam int unsigned M_TUSER_W          = 4;

  localparam logic [7:0] VARINT_W16 = 8'hFD;
  localparam logic [7:0] VARINT_W32 = 8'hFE;

  localparam logic [63:0] ERR_TRUNCATED = 64'd0;
  localparam logic [63:0] ERR_TRAILING  = 64'd1;

  typedef enum logic [3:0] {
    PH_VERSION      = 4'd0,
    PH_IN_COUNT     = 4'd1,
    PH_PREV_ID      = 4'd2,
    PH_VOUT         = 4'd3,
    PH_SIG_LEN      = 4'd4,
    PH_SIG_BYTES    = 4'd5,
    PH_SEQUENCE     = 4'd6,
    PH_OUT_COUNT    = 4'd7,
    PH_AMOUNT       = 4'd8,
    PH_SCRIPT_LEN   = 4'd9,
    PH_SCRIPT_BYTES = 4'd10,
    PH_LOCKTIME     = 4'd11,
    PH_FINISHED     = 4'd12
  } phase_e;

  typedef enum logic [3:0] {
    KIND_VERSION     = 4'd0,
    KIND_IN_COUNT    = 4'd1,
    KIND_PREV_ID     = 4'd2,
    KIND_VOUT        = 4'd3,
    KIND_SIG_LEN     = 4'd4,
    KIND_SIG_BYTE    = 4'd5,
    KIND_SEQUENCE    = 4'd6,
    KIND_OUT_COUNT   = 4'd7,
    KIND_AMOUNT      = 4'd8,
    KIND_SCRIPT_LEN  = 4'd9,
    KIND_SCRIPT_BYTE = 4'd10,
    KIND_LOCKTIME    = 4'd11,
    KIND_DONE        = 4'd12,
    KIND_ERROR       = 4'd13
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic [31:0] index;
    logic [1:0]  part;
  } res_t;

  function automatic res_t mk_res(kind_e kind, logic [63:0] value, logic [31:0] index,
                                  logic [1:0] part);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.index = index;
    r.part  = part;
    return r;
  endfunction

endpackage

>>> hw/rtl/tx_wire_parser.sv
// Streaming parser for the wire form of one transaction, byte in, tagged fields out.
`timescale 1ns / 1ps
// tx_wire_parser takes the raw bytes of a transaction, one byte per input beat, with tlast on
// the final byte, and emits every parsed field as a tagged output beat: version, input count,
// each input's previous id (four 64-bit words, display order, most significant word first),
// vout, script length, script bytes and sequence, then output count, each output's amount,
// script length and script bytes, and locktime. CompactSize counts and lengths are decoded
// and taken at face value. The string ends with a done beat, or with an error beat whose value
// is 0 for a string cut short before locktime and 1 for bytes after locktime; trailing bytes
// after the error are dropped up to the next tlast. tuser carries the field kind and tlast
// marks the last output beat caused by one input byte. Each accepted byte is parsed in its
// accept cycle and its results (up to five) land in a result buffer; the first result shows
// in the cycle after the byte is accepted. A byte that gives k results occupies the result buffer
// for k output beats, so the input sustains one byte per cycle while each byte yields at most
// one result and the output is always ready; bytes that yield no result never slow it down.
// The next byte is taken in the cycle in which the last result of the previous one leaves,
// so input tready follows output tready through one gate. There is no clearing pass after
// reset: the block takes bytes from the first cycle.
module tx_wire_parser
  import txp_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // data_byte[7:0]
  input  logic                 s_axis_tlast_i,   // last_byte
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // field_value[63:0], entry_index[95:64], word_part[97:96], zero fill [103:98]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic [M_TUSER_W-1:0] m_axis_tuser_o,   // field_kind[3:0]
  output logic                 m_axis_tlast_o    // last_result
);

  localparam int unsigned SidW = 8 * (ID_BYTES - 1);

  // Parser state.
  phase_e                phase_q, phase_d;
  logic [4:0]            bif_q, bif_d;
  logic [63:0]           acc_q, acc_d;
  logic [3:0]            vw_q, vw_d;
  logic [63:0]           left_q, left_d;
  logic [63:0]           sleft_q, sleft_d;
  logic [INDEX_BITS-1:0] cnt_q, cnt_d;
  logic                  disc_q, disc_d;
  logic [SidW-1:0]       sid_q;
  logic [8*ID_BYTES-1:0] sid_new;

  // Result buffer.
  logic       desc_v_q;
  logic [2:0] n_q, pos_q;
  res_t       slot_q [MAX_RESULTS];

  logic       s_fire, out_fire, last_beat;
  logic [7:0] b;
  logic [31:0] idx_sat;

  // The previous id shift line: the byte that arrives now sits in the lowest byte.
  assign b       = s_axis_tdata_i;
  assign sid_new = {sid_q, b};

  generate
    if (INDEX_BITS > 32) begin : g_sat
      assign idx_sat = (|cnt_q[INDEX_BITS-1:32]) ? '1 : cnt_q[31:0];
    end else begin : g_ext
      assign idx_sat = 32'(cnt_q);
    end
  endgenerate

  // Field byte assembly, shared by fixed fields and the tail of a CompactSize.
  logic [3:0]  fix_n;
  logic        is_fixed_ph, is_var_ph, fix_done, fld_done;
  logic [63:0] fix_acc, fld_val;
  logic [3:0]  pre_w;

  always_comb begin
    is_fixed_ph = 1'b0;
    is_var_ph   = 1'b0;
    fix_n       = vw_q;
    case (phase_q)
      PH_VERSION, PH_VOUT, PH_SEQUENCE, PH_LOCKTIME: begin
        is_fixed_ph = 1'b1;
        fix_n       = 4'd4;
      end
      PH_AMOUNT: begin
        is_fixed_ph = 1'b1;
        fix_n       = 4'd8;
      end
      PH_IN_COUNT, PH_SIG_LEN, PH_OUT_COUNT, PH_SCRIPT_LEN: begin
        is_var_ph = 1'b1;
      end
      default: begin
      end
    endcase
    fix_acc  = acc_q | ({56'd0, b} << {bif_q[2:0], 3'b000});
    fix_done = ({1'b0, fix_n} == (bif_q + 5'd1));
    if (is_var_ph && (vw_q == 4'd0)) begin
      fld_done = (b < VARINT_W16);
      fld_val  = {56'd0, b};
    end else begin
      fld_done = fix_done;
      fld_val  = fix_acc;
    end
    if (b == VARINT_W16) begin
      pre_w = 4'd2;
    end else if (b == VARINT_W32) begin
      pre_w = 4'd4;
    end else begin
      pre_w = 4'd8;
    end
  end

  // Results of the byte in hand.
  logic       main_v, id_v, tail_v, do_reset, sid_shift;
  res_t       main_r, tail_r;
  res_t       id_r [ID_WORDS];
  logic [2:0] n_new;

  always_comb begin
    logic [63:0] w;
    for (int k = 0; k < ID_WORDS; k++) begin
      w = '0;
      for (int i = 0; i < 8; i++) begin
        w[8*(7-i) +: 8] = sid_new[8*(8*k+i) +: 8];
      end
      id_r[k] = mk_res(KIND_PREV_ID, w, idx_sat, 2'(k));
    end
  end

  always_comb begin
    phase_d   = phase_q;
    bif_d     = bif_q;
    acc_d     = acc_q;
    vw_d      = vw_q;
    left_d    = left_q;
    sleft_d   = sleft_q;
    cnt_d     = cnt_q;
    disc_d    = disc_q;
    main_v    = 1'b0;
    main_r    = mk_res(KIND_VERSION, '0, '0, '0);
    id_v      = 1'b0;
    tail_v    = 1'b0;
    tail_r    = mk_res(KIND_DONE, '0, '0, '0);
    do_reset  = 1'b0;
    sid_shift = 1'b0;

    if (s_fire) begin
      if (disc_q) begin
        // Dropping trailing bytes up to the end of the string.
        if (s_axis_tlast_i) begin
          disc_d   = 1'b0;
          do_reset = 1'b1;
        end
      end else if (phase_q == PH_FINISHED) begin
        main_v = 1'b1;
        main_r = mk_res(KIND_ERROR, ERR_TRAILING, '0, '0);
        if (s_axis_tlast_i) begin
          do_reset = 1'b1;
        end else begin
          disc_d = 1'b1;
        end
      end else begin
        // Byte assembly for fixed fields and the body of a CompactSize.
        if (is_fixed_ph || (is_var_ph && (vw_q != 4'd0))) begin
          acc_d = fix_done ? '0 : fix_acc;
          bif_d = fix_done ? '0 : bif_q + 5'd1;
          if (fix_done) begin
            vw_d = '0;
          end
        end else if (is_var_ph && !fld_done) begin
          vw_d  = pre_w;
          acc_d = '0;
          bif_d = '0;
        end

        case (phase_q)
          PH_VERSION: begin
            if (fld_done) begin
              main_v  = 1'b1;
              main_r  = mk_res(KIND_VERSION, fld_val, '0, '0);
              phase_d = PH_IN_COUNT;
            end
          end
          PH_IN_COUNT: begin
            if (fld_done) begin
              main_v  = 1'b1;
              main_r  = mk_res(KIND_IN_COUNT, fld_val, '0, '0);
              left_d  = fld_val;
              cnt_d   = '0;
              phase_d = (fld_val == '0) ? PH_OUT_COUNT : PH_PREV_ID;
            end
          end
          PH_PREV_ID: begin
            sid_shift = 1'b1;
            if (bif_q == 5'(ID_BYTES - 1)) begin
              id_v    = 1'b1;
              bif_d   = '0;
              phase_d = PH_VOUT;
            end else begin
              bif_d = bif_q + 5'd1;
            end
          end
          PH_VOUT: begin
            if (fld_done) begin
              main_v  = 1'b1;
              main_r  = mk_res(KIND_VOUT, fld_val, idx_sat, '0);
              phase_d = PH_SIG_LEN;
            end
          end
          PH_SIG_LEN: begin
            if (fld_done) begin
              main_v  = 1'b1;
              main_r  = mk_res(KIND_SIG_LEN, fld_val, idx_sat, '0);
              sleft_d = fld_val;
              phase_d = (fld_val == '0) ? PH_SEQUENCE : PH_SIG_BYTES;
            end
          end
          PH_SIG_BYTES: begin
            main_v  = 1'b1;
            main_r  = mk_res(KIND_SIG_BYTE, {56'd0, b}, idx_sat, '0);
            sleft_d = sleft_q - 64'd1;
            if (sleft_q == 64'd1) begin
              phase_d = PH_SEQUENCE;
            end
          end
          PH_SEQUENCE: begin
            if (fld_done) begin
              main_v  = 1'b1;
              main_r  = mk_res(KIND_SEQUENCE, fld_val, idx_sat, '0);
              left_d  = left_q - 64'd1;
              cnt_d   = (cnt_q != '1) ? cnt_q + INDEX_BITS'(1) : cnt_q;
              phase_d = (left_q == 64'd1) ? PH_OUT_COUNT : PH_PREV_ID;
            end
          end
          PH_OUT_COUNT: begin
            if (fld_done) begin
              main_v  = 1'b1;
              main_r  = mk_res(KIND_OUT_COUNT, fld_val, '0, '0);
              left_d  = fld_val;
              cnt_d   = '0;
              phase_d = (fld_val == '0) ? PH_LOCKTIME : PH_AMOUNT;
            end
          end
          PH_AMOUNT: begin
            if (fld_done) begin
              main_v  = 1'b1;
              main_r  = mk_res(KIND_AMOUNT, fld_val, idx_sat, '0);
              phase_d = PH_SCRIPT_LEN;
            end
          end
          PH_SCRIPT_LEN: begin
            if (fld_done) begin
              main_v  = 1'b1;
              main_r  = mk_res(KIND_SCRIPT_LEN, fld_val, idx_sat, '0);
              sleft_d = fld_val;
              if (fld_val == '0) begin
                left_d  = left_q - 64'd1;
                cnt_d   = (cnt_q != '1) ? cnt_q + INDEX_BITS'(1) : cnt_q;
                phase_d = (left_q == 64'd1) ? PH_LOCKTIME : PH_AMOUNT;
              end else begin
                phase_d = PH_SCRIPT_BYTES;
              end
            end
          end
          PH_SCRIPT_BYTES: begin
            main_v  = 1'b1;
            main_r  = mk_res(KIND_SCRIPT_BYTE, {56'd0, b}, idx_sat, '0);
            sleft_d = sleft_q - 64'd1;
            if (sleft_q == 64'd1) begin
              left_d  = left_q - 64'd1;
              cnt_d   = (cnt_q != '1) ? cnt_q + INDEX_BITS'(1) : cnt_q;
              phase_d = (left_q == 64'd1) ? PH_LOCKTIME : PH_AMOUNT;
            end
          end
          PH_LOCKTIME: begin
            if (fld_done) begin
              main_v  = 1'b1;
              main_r  = mk_res(KIND_LOCKTIME, fld_val, '0, '0);
              phase_d = PH_FINISHED;
            end
          end
          default: begin
          end
        endcase

        // End of string: done if locktime just completed, else the string was cut short.
        if (s_axis_tlast_i) begin
          tail_v   = 1'b1;
          tail_r   = (phase_d == PH_FINISHED) ? mk_res(KIND_DONE, '0, '0, '0)
                                              : mk_res(KIND_ERROR, ERR_TRUNCATED, '0, '0);
          do_reset = 1'b1;
        end
      end
    end

    if (do_reset) begin
      phase_d = PH_VERSION;
      bif_d   = '0;
      acc_d   = '0;
      vw_d    = '0;
      left_d  = '0;
      sleft_d = '0;
      cnt_d   = '0;
    end
  end

  // Result count of this byte: its body (none, one field or four id words), then the tail.
  always_comb begin
    n_new = id_v ? 3'd4 : (main_v ? 3'd1 : 3'd0);
    if (tail_v) begin
      n_new = n_new + 3'd1;
    end
  end

  // Handshakes.
  assign last_beat       = (pos_q == (n_q - 3'd1));
  assign out_fire        = desc_v_q && m_axis_tready_i;
  assign s_axis_tready_o = !desc_v_q || (m_axis_tready_i && last_beat);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VERSION;
      bif_q   <= '0;
      acc_q   <= '0;
      vw_q    <= '0;
      left_q  <= '0;
      sleft_q <= '0;
      cnt_q   <= '0;
      disc_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bif_q   <= bif_d;
      acc_q   <= acc_d;
      vw_q    <= vw_d;
      left_q  <= left_d;
      sleft_q <= sleft_d;
      cnt_q   <= cnt_d;
      disc_q  <= disc_d;
    end
  end

  // The id bytes are always fully written before they are read, so no reset here.
  always_ff @(posedge clk_i) begin
    if (sid_shift) begin
      sid_q <= sid_new[SidW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_v_q <= 1'b0;
      n_q      <= '0;
      pos_q    <= '0;
    end else begin
      if (out_fire) begin
        if (last_beat) begin
          desc_v_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
      if (s_fire && (n_new != 3'd0)) begin
        desc_v_q <= 1'b1;
        n_q      <= n_new;
        pos_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && (n_new != 3'd0)) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (id_v && (i < ID_WORDS)) begin
          slot_q[i] <= id_r[i];
        end else if (main_v && (i == 0)) begin
          slot_q[i] <= main_r;
        end else begin
          slot_q[i] <= tail_r;
        end
      end
    end
  end

  // Output beat.
  res_t cur_r;
  assign cur_r           = slot_q[pos_q];
  assign m_axis_tvalid_o = desc_v_q;
  assign m_axis_tdata_o  = {6'd0, cur_r.part, cur_r.index, cur_r.value};
  assign m_axis_tuser_o  = cur_r.kind;
  assign m_axis_tlast_o  = last_beat;

`include "tx_wire_parser_assert.svh"

  `TXP_ASSERT(a_pos_in_range, desc_v_q |-> (pos_q < n_q) && (n_q <= 3'(MAX_RESULTS)), "result position beyond count")
  `TXP_ASSERT(a_end_is_last, m_axis_tvalid_o && ((cur_r.kind == KIND_DONE) || (cur_r.kind == KIND_ERROR)) |-> m_axis_tlast_o, "done or error not last of its byte")
  `TXP_ASSERT(a_part_only_id, m_axis_tvalid_o && (cur_r.part != 2'd0) |-> (cur_r.kind == KIND_PREV_ID), "word part on a non-id field")
  `TXP_ASSERT(a_discard_finished, disc_q |-> (phase_q == PH_FINISHED), "dropping bytes outside finished phase")
  `TXP_ASSERT(a_varint_count, (vw_q != 4'd0) |-> (bif_q < {1'b0, vw_q}), "CompactSize byte count overrun")

endmodule
